// ----- rtl/core/xrg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types and constants for the xoshiro256** generator.
// ----------------------------------------------------------------------------
package xrg_pkg;

	localparam int WordW   = 64;
	localparam int NumWords = 4;
	localparam int FracW   = 53;
	localparam int AddrW   = 4;
	localparam int WidxW   = $clog2(NumWords);

	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	localparam logic [0:0] REG_SEED = 1'b0;

	localparam logic [WordW-1:0] INIT_WORDS [NumWords] = '{
		64'h853c49e6748fea9b,
		64'hda3e39cb94b95bdb,
		64'h7e46e4d7c5f3b298,
		64'h1a2b3c4d5e6f7a8b
	};

	localparam logic [WordW-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [WordW-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [WordW-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

	localparam logic [1:0] MUL_LAST_STEP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRAW_OUT,
		ST_RS_MIX,
		ST_RS_MULA,
		ST_RS_POSTA,
		ST_RS_MULB,
		ST_RS_STORE
	} state_t;

	typedef struct packed {
		logic             draw_load;
		logic             emit;
		logic             seed_init;
		logic             mix;
		logic             mul_en;
		logic [1:0]       mul_step;
		logic             mul_sel_b;
		logic             post_a;
		logic             store;
		logic [WidxW-1:0] widx;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/xrg_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrg_cfg
// Configuration register file: holds the 64-bit seed.
// ----------------------------------------------------------------------------
module xrg_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [xrg_pkg::AddrW-1:0] paddr,
	input  logic [xrg_pkg::WordW-1:0] pwdata,
	output logic [xrg_pkg::WordW-1:0] prdata,
	output logic [xrg_pkg::WordW-1:0] seed
);
	import xrg_pkg::*;

	logic [WordW-1:0] seed_q;
	logic             hit;
	logic             wr_en;

	// one 8-byte register; byte lanes below bit 3 are not decoded
	assign hit   = (paddr[AddrW-1:3] == {(AddrW-3){1'b0}}) && (paddr[3] == REG_SEED);
	assign wr_en = psel && penable && pwrite && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (wr_en) begin
			seed_q <= pwdata;
		end
	end

	always_comb begin
		prdata = hit ? seed_q : '0;
		if (paddr[2:0] != 3'd0) begin
			prdata = hit ? seed_q : '0;
		end
	end

	assign seed = seed_q;

endmodule

// ----- rtl/core/xrg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrg_ctrl
// Sequencer for draw and reseed words; drives the datapath commands.
// ----------------------------------------------------------------------------
module xrg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          opcode,
	input  xrg_pkg::sts_t sts,
	output xrg_pkg::cmd_t cmd,
	output logic          in_stall
);
	import xrg_pkg::*;

	state_t           state_q, state_nx;
	logic [1:0]       step_q;
	logic [WidxW-1:0] w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			w_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_RS_MULA || state_q == ST_RS_MULB) begin
				step_q <= (step_q == MUL_LAST_STEP) ? 2'd0 : step_q + 2'd1;
			end
			if (cmd.seed_init) begin
				w_q <= '0;
			end else if (cmd.store) begin
				w_q <= w_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = (opcode == OP_RESEED) ? ST_RS_MIX : ST_DRAW_OUT;
				end
			end
			ST_DRAW_OUT: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_RS_MIX:   state_nx = ST_RS_MULA;
			ST_RS_MULA: begin
				if (step_q == MUL_LAST_STEP) begin
					state_nx = ST_RS_POSTA;
				end
			end
			ST_RS_POSTA: state_nx = ST_RS_MULB;
			ST_RS_MULB: begin
				if (step_q == MUL_LAST_STEP) begin
					state_nx = ST_RS_STORE;
				end
			end
			ST_RS_STORE: begin
				state_nx = (w_q == WidxW'(NumWords - 1)) ? ST_IDLE : ST_RS_MIX;
			end
			default:     state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.mul_step = step_q;
		cmd.widx     = w_q;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.draw_load = (opcode == OP_DRAW);
					cmd.seed_init = (opcode == OP_RESEED);
				end
			end
			ST_DRAW_OUT: cmd.emit = sts.out_free;
			ST_RS_MIX:   cmd.mix = 1'b1;
			ST_RS_MULA:  cmd.mul_en = 1'b1;
			ST_RS_POSTA: cmd.post_a = 1'b1;
			ST_RS_MULB: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_b = 1'b1;
			end
			ST_RS_STORE: cmd.store = 1'b1;
			default:     cmd = '0;
		endcase
	end

endmodule

// ----- rtl/core/xrg_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrg_dp
// Datapath: generator state, output scrambler, SplitMix64 expansion with a
// shared 32x32 multiplier, and the output register.
// ----------------------------------------------------------------------------
module xrg_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  xrg_pkg::cmd_t             cmd,
	output xrg_pkg::sts_t             sts,
	input  logic [xrg_pkg::WordW-1:0] seed,
	input  logic                      last_of_batch,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [xrg_pkg::WordW-1:0] raw_value,
	output logic [xrg_pkg::FracW-1:0] uniform_fraction,
	output logic                      last
);
	import xrg_pkg::*;

	logic [WordW-1:0] gen_q [NumWords];
	logic [WordW-1:0] t_q;
	logic             mark_q;
	logic [WordW-1:0] raw_q;
	logic             last_q;
	logic             valid_q;
	logic [WordW-1:0] ctr_q;
	logic [WordW-1:0] z_q;
	logic [WordW-1:0] acc_q;

	logic [WordW-1:0] n0, n1, n2, n3, n3x;
	logic [WordW-1:0] rot7, scr;
	logic [WordW-1:0] ctr_nx;
	logic [WordW-1:0] mul_k;
	logic [31:0]      mul_a, mul_b;
	logic [WordW-1:0] pp;

	// xoshiro256 step
	always_comb begin
		n2  = gen_q[2] ^ gen_q[0];
		n3x = gen_q[3] ^ gen_q[1];
		n1  = gen_q[1] ^ n2;
		n0  = gen_q[0] ^ n3x;
		n2  = n2 ^ {gen_q[1][WordW-18:0], 17'd0};
		n3  = {n3x[WordW-46:0], n3x[WordW-1:WordW-45]};
	end

	// scrambler second half: rotl(t, 7) * 9
	assign rot7 = {t_q[WordW-8:0], t_q[WordW-1:WordW-7]};
	assign scr  = {rot7[WordW-4:0], 3'd0} + rot7;

	assign ctr_nx = ctr_q + GOLDEN_GAMMA;

	// low 64 bits of z * k over three partial products
	assign mul_k = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
	always_comb begin
		case (cmd.mul_step)
			2'd0: begin
				mul_a = z_q[31:0];
				mul_b = mul_k[31:0];
			end
			2'd1: begin
				mul_a = z_q[31:0];
				mul_b = mul_k[63:32];
			end
			default: begin
				mul_a = z_q[63:32];
				mul_b = mul_k[31:0];
			end
		endcase
	end
	assign pp = WordW'(mul_a) * WordW'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumWords; i++) begin
				gen_q[i] <= INIT_WORDS[i];
			end
		end else if (cmd.draw_load) begin
			gen_q[0] <= n0;
			gen_q[1] <= n1;
			gen_q[2] <= n2;
			gen_q[3] <= n3;
		end else if (cmd.store) begin
			gen_q[cmd.widx] <= acc_q ^ (acc_q >> 31);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_load) begin
			t_q    <= {gen_q[1][WordW-3:0], 2'd0} + gen_q[1];
			mark_q <= last_of_batch;
		end
		if (cmd.emit) begin
			raw_q  <= scr;
			last_q <= mark_q;
		end
		if (cmd.seed_init) begin
			ctr_q <= seed;
		end else if (cmd.mix) begin
			ctr_q <= ctr_nx;
		end
		if (cmd.mix) begin
			z_q <= ctr_nx ^ (ctr_nx >> 30);
		end else if (cmd.post_a) begin
			z_q <= acc_q ^ (acc_q >> 27);
		end
		if (cmd.mul_en) begin
			if (cmd.mul_step == 2'd0) begin
				acc_q <= pp;
			end else begin
				acc_q <= acc_q + {pp[31:0], 32'd0};
			end
		end
	end

	assign sts.out_free      = !valid_q || !out_stall;
	assign out_valid         = valid_q;
	assign raw_value         = raw_q;
	assign uniform_fraction  = raw_q[WordW-1:WordW-FracW];
	assign last              = last_q;

endmodule

// ----- rtl/core/xoshiro_random_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro_random_generator
// xoshiro256** generator with SplitMix64 reseeding from a seed register.
// ----------------------------------------------------------------------------
// A draw word steps the state and registers s1*5 on acceptance, then loads
// rotl(.,7)*9 into the output register. The block takes the next word while
// a result waits, but holds a draw before that load until the output register
// is free. A reseed word gives no result: it loads the counter on acceptance,
// then for each state word adds the gamma, runs two 64-bit multiplies on one
// 32x32 multiplier between the mixing steps, and stores the word. The seed
// register sits at byte address 0 and is read back.
module xoshiro_random_generator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic                      last_of_batch,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [xrg_pkg::WordW-1:0] raw_value,
	output logic [xrg_pkg::FracW-1:0] uniform_fraction,
	output logic                      last,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [xrg_pkg::AddrW-1:0] paddr,
	input  logic [xrg_pkg::WordW-1:0] pwdata,
	output logic [xrg_pkg::WordW-1:0] prdata,
	output logic                      pready
);
	import xrg_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [WordW-1:0] seed;

	assign pready = 1'b1;

	xrg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.seed    (seed)
	);

	xrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	xrg_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.seed             (seed),
		.last_of_batch    (last_of_batch),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.raw_value        (raw_value),
		.uniform_fraction (uniform_fraction),
		.last             (last)
	);

	// a reseed never produces a result word
	a_reseed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_RESEED) |=> !$rose(out_valid))
		else $error("result word after reseed");

	// a draw into an empty output register is shown after the output state loads the result register
	a_draw_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_DRAW && !out_valid) |-> ##2 out_valid)
		else $error("draw result late");

	// a new result only appears after a busy cycle
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without draw in progress");

endmodule

// ----- sim/xoshiro_random_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro_random_generator_tb
// Self-checking bench for the xoshiro256** generator: a short table of
// directed words (draws after reset, reseeds from zero, all-ones and sparse
// seeds, an ignored mark on reseed, a write to an unmapped register), then
// random batches of draws with occasional reseeds and seed changes. Every
// draw is checked against an in-bench model of the generator and the
// SplitMix64 refill. Both sides idle in random bursts, except near the end.
// ----------------------------------------------------------------------------
module xoshiro_random_generator_tb;
	import xrg_pkg::*;

	localparam int RANDOM_WORDS  = 1950;
	localparam int CALM_FROM     = 1650;
	localparam int SETTLE_CYCLES = 48;
	localparam int STUCK_LIMIT   = 4000;
	localparam logic [AddrW-1:0] SEED_ADDR  = AddrW'(8 * int'(REG_SEED));
	localparam logic [AddrW-1:0] UNUSED_ADDR = AddrW'(8 * (int'(REG_SEED) + 1));

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_SEED,
		ROW_UNUSED_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic        mark;
		logic        want_last;
		logic [63:0] data;
	} stim_row_t;

	typedef struct packed {
		logic [WordW-1:0] raw;
		logic [FracW-1:0] frac;
		logic             last;
	} draw_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             opcode = OP_DRAW;
	logic             last_of_batch = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [WordW-1:0] raw_value;
	logic [FracW-1:0] uniform_fraction;
	logic             last;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [WordW-1:0] pwdata = '0;
	logic [WordW-1:0] prdata;
	logic             pready;

	logic [WordW-1:0] gen_state [NumWords];
	logic [WordW-1:0] seed_reg;
	draw_t            expected_draws [$];
	int               mismatches = 0;
	int               stuck_cycles = 0;
	bit               no_idling = 1'b0;

	stim_row_t directed_rows [24] = '{
		'{ROW_WORD,       OP_DRAW,   1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b1, 1'b1, 64'h0},
		'{ROW_WORD,       OP_RESEED, 1'b1, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b1, 1'b1, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b0, 1'b0, 64'h0},
		'{ROW_SEED,       OP_DRAW,   1'b0, 1'b0, 64'hffff_ffff_ffff_ffff},
		'{ROW_WORD,       OP_RESEED, 1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b1, 1'b1, 64'h0},
		'{ROW_UNUSED_REG, OP_DRAW,   1'b0, 1'b0, 64'h5a5a_a5a5_5a5a_a5a5},
		'{ROW_WORD,       OP_RESEED, 1'b1, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b0, 1'b0, 64'h0},
		'{ROW_SEED,       OP_DRAW,   1'b0, 1'b0, 64'h8000_0000_0000_0000},
		'{ROW_WORD,       OP_RESEED, 1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_RESEED, 1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b1, 1'b1, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b0, 1'b0, 64'h0},
		'{ROW_SEED,       OP_DRAW,   1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_RESEED, 1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b1, 1'b1, 64'h0},
		'{ROW_SEED,       OP_DRAW,   1'b0, 1'b0, 64'h1},
		'{ROW_WORD,       OP_DRAW,   1'b0, 1'b0, 64'h0},
		'{ROW_WORD,       OP_RESEED, 1'b1, 1'b0, 64'h0},
		'{ROW_WORD,       OP_DRAW,   1'b1, 1'b1, 64'h0}
	};

	xoshiro_random_generator u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.last_of_batch    (last_of_batch),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.raw_value        (raw_value),
		.uniform_fraction (uniform_fraction),
		.last             (last),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [WordW-1:0] rotl64(logic [WordW-1:0] v, int unsigned n);
		return (v << n) | (v >> (WordW - n));
	endfunction

	function automatic logic [WordW-1:0] step_generator();
		logic [WordW-1:0] out_w;
		logic [WordW-1:0] shifted;
		out_w = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
		shifted = gen_state[1] << 17;
		gen_state[2] ^= gen_state[0];
		gen_state[3] ^= gen_state[1];
		gen_state[1] ^= gen_state[2];
		gen_state[0] ^= gen_state[3];
		gen_state[2] ^= shifted;
		gen_state[3] = rotl64(gen_state[3], 45);
		return out_w;
	endfunction

	function automatic void refill_from_seed();
		logic [WordW-1:0] ctr;
		logic [WordW-1:0] z;
		ctr = seed_reg;
		for (int w = 0; w < NumWords; w++) begin
			ctr += GOLDEN_GAMMA;
			z = ctr;
			z = (z ^ (z >> 30)) * MIX_MUL_A;
			z = (z ^ (z >> 27)) * MIX_MUL_B;
			gen_state[w] = z ^ (z >> 31);
		end
	endfunction

	task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
		mismatches++;
		$display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
	endtask

	task automatic send_word(logic op, logic mark, logic want_last);
		logic [WordW-1:0] raw;
		@(negedge clk);
		opcode <= op;
		last_of_batch <= mark;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		if (op == OP_DRAW) begin
			raw = step_generator();
			expected_draws.push_back('{raw, raw[WordW-1:WordW-FracW], want_last});
		end else begin
			refill_from_seed();
		end
	endtask

	task automatic idle_input(int unsigned n);
		@(negedge clk);
		in_valid <= 1'b0;
		opcode <= 1'($urandom);
		last_of_batch <= 1'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// drain all results, then let any reseed finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [AddrW-1:0] addr, logic [WordW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == SEED_ADDR) seed_reg = data;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		paddr <= SEED_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== seed_reg) report_mismatch("seed readback", prdata, seed_reg);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		draw_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_draws.size() == 0) begin
				report_mismatch("unexpected word", raw_value, '0);
			end else begin
				want = expected_draws.pop_front();
				if (raw_value !== want.raw) report_mismatch("raw_value", raw_value, want.raw);
				if (uniform_fraction !== want.frac)
					report_mismatch("uniform_fraction", 64'(uniform_fraction), 64'(want.frac));
				if (last !== want.last) report_mismatch("last", 64'(last), 64'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : out_stall_gen
		int unsigned span;
		bit stalling;
		forever begin
			span = $urandom_range(16, 160);
			stalling = ($urandom_range(0, 3) != 0);
			repeat (span) begin
				@(negedge clk);
				if (stalling && !no_idling && $urandom_range(0, 5) == 0) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 15)) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int phase_len;
		int batch_left;
		bit calm;
		logic op;
		logic mark;
		logic [WordW-1:0] seed;
		for (int w = 0; w < NumWords; w++) gen_state[w] = INIT_WORDS[w];
		seed_reg = '0;
		sent = 0;
		batch_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_WORD: begin
					send_word(directed_rows[i].op, directed_rows[i].mark,
						directed_rows[i].want_last);
				end
				ROW_SEED: begin
					settle();
					write_register(SEED_ADDR, directed_rows[i].data);
				end
				default: begin
					settle();
					write_register(UNUSED_ADDR, directed_rows[i].data);
				end
			endcase
		end

		while (sent < RANDOM_WORDS) begin
			phase_len = $urandom_range(60, 240);
			calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
				no_idling = (sent >= CALM_FROM);
				if (!no_idling && !calm && $urandom_range(0, 7) == 0)
					idle_input($urandom_range(1, 15));
				if ($urandom_range(0, 24) == 0) begin
					op = OP_RESEED;
					mark = 1'($urandom);
				end else begin
					op = OP_DRAW;
					if (batch_left == 0) batch_left = $urandom_range(1, 16);
					mark = (batch_left == 1);
					batch_left--;
				end
				send_word(op, mark, mark);
				sent++;
			end
			if (sent < CALM_FROM) begin
				settle();
				case ($urandom_range(0, 5))
					0: seed = '0;
					1: seed = '1;
					default: seed = {$urandom, $urandom};
				endcase
				if ($urandom_range(0, 4) == 0) write_register(UNUSED_ADDR, ~seed);
				write_register(SEED_ADDR, seed);
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/xrg_pkg.sv
rtl/core/xrg_cfg.sv
rtl/core/xrg_ctrl.sv
rtl/core/xrg_dp.sv
rtl/core/xoshiro_random_generator.sv
sim/xoshiro_random_generator_tb.sv
